FILE: rtl/brtp_pkg.sv
// shared constants and types for the blended rigid transform points unit
package brtp_pkg;

    localparam int unsigned SLOT_W        = 3;
    localparam int unsigned WIDX_W        = 4;
    localparam int unsigned COORD_W       = 32;
    localparam int unsigned WEIGHT_W      = 16;
    localparam int unsigned ROW_SEL_W     = 2;
    localparam int unsigned WORD_SEL_W    = 2;
    localparam int unsigned ROWS_PER_TFM  = 3;
    localparam int unsigned WORDS_PER_ROW = 4;
    localparam int unsigned TFM_WORDS     = 12;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

    // operation field codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    localparam logic [ROW_SEL_W-1:0] LAST_ROW = ROW_SEL_W'(ROWS_PER_TFM - 1);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'b01,
        CMD_POINT = 2'b10
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic                        slot_ok;
        logic [SLOT_W-1:0]           slot;
        logic [WIDX_W-1:0]           widx;
        logic signed [COORD_W-1:0]   wval;
        logic signed [COORD_W-1:0]   x;
        logic signed [COORD_W-1:0]   y;
        logic signed [COORD_W-1:0]   z;
        logic signed [WEIGHT_W-1:0]  weight;
        logic                        last;
    } cmd_t;

endpackage

FILE: rtl/brtp_if.sv
// channel interfaces for item and result beats
interface brtp_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic [brtp_pkg::SLOT_W-1:0]           slot;
    logic [brtp_pkg::WIDX_W-1:0]           word_index;
    logic signed [brtp_pkg::COORD_W-1:0]   word_value;
    logic signed [brtp_pkg::COORD_W-1:0]   x;
    logic signed [brtp_pkg::COORD_W-1:0]   y;
    logic signed [brtp_pkg::COORD_W-1:0]   z;
    logic signed [brtp_pkg::WEIGHT_W-1:0]  weight;
    logic                                  last;

    modport source (
        output valid, operation, slot, word_index, word_value, x, y, z, weight, last,
        input  ready
    );
    modport sink (
        input  valid, operation, slot, word_index, word_value, x, y, z, weight, last,
        output ready
    );
endinterface

interface brtp_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [brtp_pkg::COORD_W-1:0]   out_x;
    logic signed [brtp_pkg::COORD_W-1:0]   out_y;
    logic signed [brtp_pkg::COORD_W-1:0]   out_z;

    modport source (
        output valid, out_x, out_y, out_z,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z,
        output ready
    );
endinterface

FILE: rtl/blended_rigid_transform_points_unit.sv
// top level of the blended rigid transform points unit
// throughput: loads one per cycle while the back is idle; point beats are paced by
//   three row reads through the single table read port and the four-stage row pipeline
//   draining into the accumulators before the next beat is taken
// reset: async active low clears control, queue and accumulators; table is not cleared
module blended_rigid_transform_points_unit #(
    parameter int MAX_TRANSFORMS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    brtp_in_if.sink     items,
    brtp_out_if.source  results
);

    // front to queue
    brtp_pkg::cmd_t front_cmd;
    logic           front_valid;
    logic           front_ready;

    // queue to back
    brtp_pkg::cmd_t back_cmd;
    logic           back_valid;
    logic           back_ready;

    // front classifies each beat; loads that miss the table are dropped here
    brtp_front #(
        .MAX_TRANSFORMS (MAX_TRANSFORMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .cmd        (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready)
    );

    // two-entry queue lets the front keep taking beats while the back is busy
    brtp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // back holds the table, works a point one matrix row a cycle and owns the
    // result register, so a waiting result never blocks the queue from filling
    brtp_back #(
        .MAX_TRANSFORMS (MAX_TRANSFORMS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .results   (results)
    );

endmodule

FILE: rtl/brtp_front.sv
// front end: takes item beats, classifies them and drops loads that have no effect
module brtp_front #(
    parameter int MAX_TRANSFORMS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    brtp_in_if.sink         items,
    output brtp_pkg::cmd_t  cmd,
    output logic            push_valid,
    input  logic            push_ready
);

    localparam int unsigned CMP_W = brtp_pkg::SLOT_W + 2;

    logic run_reg;
    logic run_next;
    logic slot_in_range;
    logic widx_in_range;
    logic is_point;
    logic keep;

    assign run_next = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_comb
    begin
        slot_in_range = CMP_W'(items.slot) < CMP_W'(MAX_TRANSFORMS);
        widx_in_range = items.word_index < brtp_pkg::WIDX_W'(brtp_pkg::TFM_WORDS);
        is_point      = (items.operation == brtp_pkg::OP_POINT);
        // a load outside the table never changes anything
        keep          = is_point || (slot_in_range && widx_in_range);

        cmd.kind    = is_point ? brtp_pkg::CMD_POINT : brtp_pkg::CMD_LOAD;
        cmd.slot_ok = is_point ? slot_in_range : (slot_in_range && widx_in_range);
        cmd.slot    = items.slot;
        cmd.widx    = items.word_index;
        cmd.wval    = items.word_value;
        cmd.x       = items.x;
        cmd.y       = items.y;
        cmd.z       = items.z;
        cmd.weight  = items.weight;
        cmd.last    = items.last;
    end

    assign items.ready = run_reg && push_ready;
    assign push_valid  = run_reg && items.valid && keep;

endmodule

FILE: rtl/brtp_queue.sv
// short command queue between front and back
module brtp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  brtp_pkg::cmd_t  push_cmd,
    input  logic            push_valid,
    output logic            push_ready,
    output brtp_pkg::cmd_t  pop_cmd,
    output logic            pop_valid,
    input  logic            pop_ready
);

    localparam int unsigned DEPTH = brtp_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = brtp_pkg::QPTR_W;

    brtp_pkg::cmd_t entry_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [PW:0]   cnt_reg;
    logic [PW:0]   cnt_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (cnt_reg < (PW+1)'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/brtp_back.sv
// back end: transform table, row pipeline, accumulators and result register
module brtp_back #(
    parameter int MAX_TRANSFORMS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  brtp_pkg::cmd_t  cmd,
    input  logic            pop_valid,
    output logic            pop_ready,
    brtp_out_if.source      results
);

    localparam int unsigned ROWS   = MAX_TRANSFORMS * brtp_pkg::ROWS_PER_TFM;
    localparam int unsigned AW     = $clog2(ROWS);
    localparam int unsigned CALC_W = brtp_pkg::SLOT_W + 2;
    localparam int unsigned CW     = brtp_pkg::COORD_W;
    localparam int unsigned WW     = brtp_pkg::WEIGHT_W;
    localparam int unsigned RSW    = brtp_pkg::ROW_SEL_W;
    localparam int unsigned NSTG   = 4;
    localparam int unsigned PROD_W = 2 * CW;
    localparam int unsigned SUM_W  = PROD_W - 16 + 2;
    localparam int unsigned WP_W   = CW + WW;
    localparam int unsigned ACC_W  = 64;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    function automatic logic signed [CW-1:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI)
        begin
            return SAT_HI[CW-1:0];
        end
        else if (v < SAT_LO)
        begin
            return SAT_LO[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [WP_W-1:0]  b
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    // transform table, one row of four words per entry
    logic [brtp_pkg::WORDS_PER_ROW-1:0][CW-1:0] mem [ROWS];
    logic [brtp_pkg::WORDS_PER_ROW-1:0][CW-1:0] rd_row_reg;

    state_t state_reg;
    state_t state_next;

    logic [RSW-1:0] row_reg;
    logic [RSW-1:0] row_next;
    logic           take;
    logic           issue;
    logic           emit;
    logic           mem_we;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic [brtp_pkg::WORD_SEL_W-1:0] wr_word;

    logic [brtp_pkg::SLOT_W-1:0] slot_reg;
    logic                        last_reg;
    logic signed [CW-1:0]        x_reg;
    logic signed [CW-1:0]        y_reg;
    logic signed [CW-1:0]        z_reg;
    logic signed [WW-1:0]        w_reg;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [RSW-1:0]  tag_reg [NSTG];

    logic signed [PROD_W-1:0] p0_reg, p0_next;
    logic signed [PROD_W-1:0] p1_reg, p1_next;
    logic signed [PROD_W-1:0] p2_reg, p2_next;
    logic signed [CW-1:0]     t_reg;
    logic signed [SUM_W-1:0]  row_sum;
    logic signed [CW-1:0]     s_reg, s_next;
    logic signed [WP_W-1:0]   q_reg, q_next;

    logic signed [ACC_W-1:0] acc_reg [brtp_pkg::ROWS_PER_TFM];
    logic signed [ACC_W-1:0] acc_upd;

    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic signed [CW-1:0] out_x_reg;
    logic signed [CW-1:0] out_y_reg;
    logic signed [CW-1:0] out_z_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        pop_ready  = 1'b0;
        take       = 1'b0;
        issue      = 1'b0;
        emit       = 1'b0;
        mem_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    if (cmd.kind == brtp_pkg::CMD_LOAD)
                    begin
                        mem_we = cmd.slot_ok;
                    end
                    else
                    begin
                        take = 1'b1;
                        if (cmd.slot_ok)
                        begin
                            state_next = ST_ISSUE;
                            row_next   = '0;
                        end
                        else if (cmd.last)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_ISSUE:
            begin
                issue    = 1'b1;
                row_next = row_reg + RSW'(1);
                if (row_reg == brtp_pkg::LAST_ROW)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (vld_reg == '0)
                begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_vld_reg || results.ready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_addr = AW'(CALC_W'(cmd.slot) * CALC_W'(brtp_pkg::ROWS_PER_TFM)
                      + CALC_W'(cmd.widx[brtp_pkg::WIDX_W-1:brtp_pkg::WORD_SEL_W]));
        wr_word = cmd.widx[brtp_pkg::WORD_SEL_W-1:0];
        rd_addr = AW'(CALC_W'(slot_reg) * CALC_W'(brtp_pkg::ROWS_PER_TFM)
                      + CALC_W'(row_reg));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr][wr_word] <= cmd.wval;
        end
        if (issue)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    // row datapath: products, floor and sum, weight, accumulate
    always_comb
    begin
        p0_next = PROD_W'($signed(rd_row_reg[0])) * PROD_W'(x_reg);
        p1_next = PROD_W'($signed(rd_row_reg[1])) * PROD_W'(y_reg);
        p2_next = PROD_W'($signed(rd_row_reg[2])) * PROD_W'(z_reg);
        row_sum = SUM_W'($signed(p0_reg[PROD_W-1:16])) + SUM_W'($signed(p1_reg[PROD_W-1:16]))
                + SUM_W'($signed(p2_reg[PROD_W-1:16])) + SUM_W'(t_reg);
        s_next  = sat32(row_sum);
        q_next  = WP_W'(s_reg) * WP_W'(w_reg);
        acc_upd = sat_add(acc_reg[tag_reg[NSTG-1]], q_reg);
        vld_next = {vld_reg[NSTG-2:0], issue};
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg <= cmd.slot;
            last_reg <= cmd.last;
            x_reg    <= cmd.x;
            y_reg    <= cmd.y;
            z_reg    <= cmd.z;
            w_reg    <= cmd.weight;
        end
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        t_reg      <= $signed(rd_row_reg[3]);
        s_reg      <= s_next;
        q_reg      <= q_next;
        tag_reg[0] <= row_reg;
        for (int i = 1; i < NSTG; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
        if (emit)
        begin
            out_x_reg <= sat32($signed(acc_reg[0][ACC_W-1:14]));
            out_y_reg <= sat32($signed(acc_reg[1][ACC_W-1:14]));
            out_z_reg <= sat32($signed(acc_reg[2][ACC_W-1:14]));
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < brtp_pkg::ROWS_PER_TFM; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
            if (emit)
            begin
                for (int i = 0; i < brtp_pkg::ROWS_PER_TFM; i++)
                begin
                    acc_reg[i] <= '0;
                end
            end
            else if (vld_reg[NSTG-1])
            begin
                acc_reg[tag_reg[NSTG-1]] <= acc_upd;
            end
        end
    end

    assign results.valid = out_vld_reg;
    assign results.out_x = out_x_reg;
    assign results.out_y = out_y_reg;
    assign results.out_z = out_z_reg;

endmodule

FILE: rtl/brtp_checker.sv
// port-level checks for the blended rigid transform points unit, with bind
module brtp_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  in_operation,
    input logic                                  in_last,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [brtp_pkg::COORD_W-1:0]   out_x,
    input logic signed [brtp_pkg::COORD_W-1:0]   out_y,
    input logic signed [brtp_pkg::COORD_W-1:0]   out_z
);

    // queue entries plus the item in work plus the result register
    localparam logic [2:0] MAX_PEND = 3'(brtp_pkg::QUEUE_DEPTH + 2);

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       ends_point;
    logic       taken;

    assign ends_point = in_valid && in_ready && (in_operation == brtp_pkg::OP_POINT) && in_last;
    assign taken      = out_valid && out_ready;
    assign pend_next  = pend_reg + 3'(ends_point) - 3'(taken);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result beat offered during reset");

    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        taken |-> pend_reg != 3'd0)
        else $error("result beat with no point marked last before it");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= MAX_PEND)
        else $error("more finished points in flight than the unit can hold");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z))
        else $error("stalled result beat dropped or changed");

endmodule

bind blended_rigid_transform_points_unit brtp_checker u_brtp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_operation (items.operation),
    .in_last      (items.last),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_x        (results.out_x),
    .out_y        (results.out_y),
    .out_z        (results.out_z)
);
